/* hw/rtl/ttlc_pkg.sv */
package ttlc_pkg;

  localparam int unsigned CAPACITY_DEF = 16;
  localparam int unsigned KEY_BITS_DEF = 32;
  localparam logic [4:0]  MAX_ENTRIES_RST = 5'd16;

  typedef enum logic [1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_SWEEP  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MATCH,
    ST_TOUCH,
    ST_EVICT,
    ST_ALLOC,
    ST_SWEEP,
    ST_DONE
  } state_e;

  typedef enum logic [2:0] {
    SEL_KEY,
    SEL_HIT,
    SEL_LRU,
    SEL_EXP,
    SEL_FREE
  } sel_e;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_MATCH,
    ACT_TOUCH,
    ACT_REMOVE,
    ACT_ALLOC
  } act_e;

  typedef struct packed {
    act_e act;
    sel_e sel;
    logic wr;
  } cell_ctl_t;

endpackage

/* hw/rtl/ttlc_cell.sv */
module ttlc_cell #(
  parameter int unsigned KW = 32,
  parameter int unsigned RW = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ttlc_pkg::cell_ctl_t ctl_i,
  input  logic [KW-1:0]     key_i,
  input  logic [31:0]       value_i,
  input  logic [31:0]       expiry_i,
  input  logic [31:0]       now_i,
  input  logic [RW-1:0]     rref_i,
  input  logic              first_i,
  input  logic              any_i,
  input  logic [RW-1:0]     rank_i,
  input  logic [31:0]       val_i,
  output logic              first_o,
  output logic              any_o,
  output logic [RW-1:0]     rank_o,
  output logic [31:0]       val_o,
  output logic              valid_o
);

  logic          valid_q, valid_d, hit_q, hit_d;
  logic [KW-1:0] key_q, key_d;
  logic [31:0]   value_q, value_d, exp_q, exp_d;
  logic [RW-1:0] rank_q, rank_d;
  logic          cand, sel;

  always_comb begin
    unique case (ctl_i.sel)
      ttlc_pkg::SEL_KEY:  cand = valid_q && (key_q == key_i);
      ttlc_pkg::SEL_HIT:  cand = hit_q;
      ttlc_pkg::SEL_LRU:  cand = valid_q && (rank_q == rref_i);
      ttlc_pkg::SEL_EXP:  cand = valid_q && (exp_q < now_i);
      ttlc_pkg::SEL_FREE: cand = !valid_q;
      default:            cand = 1'b0;
    endcase
  end

  assign sel     = cand && first_i;
  assign first_o = first_i && !cand;
  assign any_o   = any_i | sel;
  assign rank_o  = rank_i | (sel ? rank_q : '0);
  assign val_o   = val_i | (sel ? value_q : '0);
  assign valid_o = valid_q;

  always_comb begin
    valid_d = valid_q;
    hit_d   = hit_q;
    key_d   = key_q;
    value_d = value_q;
    exp_d   = exp_q;
    rank_d  = rank_q;
    unique case (ctl_i.act)
      ttlc_pkg::ACT_NONE: ;
      ttlc_pkg::ACT_MATCH: hit_d = sel;
      ttlc_pkg::ACT_TOUCH: begin
        if (sel) begin
          rank_d = '0;
          if (ctl_i.wr) begin
            value_d = value_i;
            exp_d   = expiry_i;
          end
        end else if (valid_q && rank_q < rref_i) begin
          rank_d = rank_q + 1'b1;
        end
      end
      ttlc_pkg::ACT_REMOVE: begin
        if (sel) begin
          valid_d = 1'b0;
        end else if (valid_q && rank_q > rref_i) begin
          rank_d = rank_q - 1'b1;
        end
      end
      ttlc_pkg::ACT_ALLOC: begin
        if (sel) begin
          valid_d = 1'b1;
          key_d   = key_i;
          value_d = value_i;
          exp_d   = expiry_i;
          rank_d  = '0;
        end else if (valid_q) begin
          rank_d = rank_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      hit_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      hit_q   <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    value_q <= value_d;
    exp_q   <= exp_d;
    rank_q  <= rank_d;
  end

endmodule

/* hw/rtl/ttl_lru_cache_core.sv */
// Fully associative key cache with least recently used replacement and
// expiry times, built as a chain of entry cells.
// Input channel (in_valid_i/in_ready_o): command, key, value handle,
// freshness and current time. Output channel (out_valid_o/out_ready_i):
// found flag, found value and removed count, one result per request.
// Config channel (cfg_valid_i/cfg_ready_o, cfg_data_i): entry limit,
// always ready; write only while no request is in flight.
// One request is worked at a time by the control sequencer; a new request
// is taken whenever the sequencer is idle, even while a result waits.
// Lookup and insert match, then touch on a hit; an insert miss evicts LRU
// entries to fit the limit, then allocates; sweep removes expired entries;
// other commands go to the result. Each step is one broadcast over the cell
// chain; the first-match chain through all cells sets the cycle time.
// Reset empties the cache and sets the limit to 16 entries, the default capacity.
// When the receiver stalls, the finished result holds in the output
// register and the next result waits in the sequencer until it drains.
module ttl_lru_cache_core #(
  parameter int unsigned CAPACITY = ttlc_pkg::CAPACITY_DEF,
  parameter int unsigned KEY_BITS = ttlc_pkg::KEY_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [4:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  command_i,
  input  logic [31:0] key_i,
  input  logic [31:0] value_handle_i,
  input  logic [23:0] freshness_i,
  input  logic [31:0] now_time_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        found_o,
  output logic [31:0] found_value_o,
  output logic [4:0]  removed_count_o
);

  localparam int unsigned KW = (KEY_BITS < 32) ? KEY_BITS : 32;
  localparam int unsigned RW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  ttlc_pkg::state_e state_q, state_d;
  ttlc_pkg::cmd_e   cmd_q;
  ttlc_pkg::cell_ctl_t ctl;
  logic [4:0]    max_q;
  logic [KW-1:0] key_q;
  logic [31:0]   val_q, exp_q, now_q;
  logic [CW-1:0] count_q, count_d;
  logic [4:0]    removed_q, removed_d, rco_q, rco_d;
  logic          found_q, found_d, fo_q, fo_d, ov_q, ov_d;
  logic [31:0]   fval_q, fval_d, fvo_q, fvo_d;
  logic [RW-1:0] rref_q, rref_d, rref;
  logic [32:0]   sum;
  logic [8:0]    lim;
  logic          accept;

  logic [CAPACITY:0]   ch_first, ch_any;
  logic [RW-1:0]       ch_rank [CAPACITY+1];
  logic [31:0]         ch_val  [CAPACITY+1];
  logic [CAPACITY-1:0] valid_vec;

  assign cfg_ready_o     = 1'b1;
  assign in_ready_o      = (state_q == ttlc_pkg::ST_IDLE);
  assign accept          = in_valid_i && in_ready_o;
  assign out_valid_o     = ov_q;
  assign found_o         = fo_q;
  assign found_value_o   = fvo_q;
  assign removed_count_o = rco_q;

  assign sum = {1'b0, now_time_i} + {9'd0, freshness_i};

  always_comb begin
    if (max_q == 5'd0) begin
      lim = 9'd1;
    end else if (9'(max_q) > 9'(CAPACITY)) begin
      lim = 9'(CAPACITY);
    end else begin
      lim = 9'(max_q);
    end
  end

  assign ch_first[0] = 1'b1;
  assign ch_any[0]   = 1'b0;
  assign ch_rank[0]  = '0;
  assign ch_val[0]   = '0;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    ttlc_cell #(.KW(KW), .RW(RW)) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctl_i    (ctl),
      .key_i    (key_q),
      .value_i  (val_q),
      .expiry_i (exp_q),
      .now_i    (now_q),
      .rref_i   (rref),
      .first_i  (ch_first[g]),
      .any_i    (ch_any[g]),
      .rank_i   (ch_rank[g]),
      .val_i    (ch_val[g]),
      .first_o  (ch_first[g+1]),
      .any_o    (ch_any[g+1]),
      .rank_o   (ch_rank[g+1]),
      .val_o    (ch_val[g+1]),
      .valid_o  (valid_vec[g])
    );
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ttlc_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (ttlc_pkg::cmd_e'(command_i))
            ttlc_pkg::CMD_LOOKUP, ttlc_pkg::CMD_INSERT: state_d = ttlc_pkg::ST_MATCH;
            ttlc_pkg::CMD_SWEEP: state_d = ttlc_pkg::ST_SWEEP;
            default:             state_d = ttlc_pkg::ST_DONE;
          endcase
        end
      end
      ttlc_pkg::ST_MATCH: begin
        priority if (ch_any[CAPACITY])        state_d = ttlc_pkg::ST_TOUCH;
        else if (cmd_q == ttlc_pkg::CMD_INSERT) state_d = ttlc_pkg::ST_EVICT;
        else                                   state_d = ttlc_pkg::ST_DONE;
      end
      ttlc_pkg::ST_TOUCH: state_d = ttlc_pkg::ST_DONE;
      ttlc_pkg::ST_EVICT: begin
        if (9'(count_q) < lim) state_d = ttlc_pkg::ST_ALLOC;
      end
      ttlc_pkg::ST_ALLOC: state_d = ttlc_pkg::ST_DONE;
      ttlc_pkg::ST_SWEEP: begin
        if (!ch_any[CAPACITY]) state_d = ttlc_pkg::ST_DONE;
      end
      ttlc_pkg::ST_DONE: begin
        if (!ov_q || out_ready_i) state_d = ttlc_pkg::ST_IDLE;
      end
      default: state_d = ttlc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctl       = '{act: ttlc_pkg::ACT_NONE, sel: ttlc_pkg::SEL_KEY, wr: 1'b0};
    rref      = rref_q;
    count_d   = count_q;
    removed_d = removed_q;
    found_d   = found_q;
    fval_d    = fval_q;
    rref_d    = rref_q;
    ov_d      = ov_q;
    fo_d      = fo_q;
    fvo_d     = fvo_q;
    rco_d     = rco_q;
    if (ov_q && out_ready_i) ov_d = 1'b0;
    unique case (state_q)
      ttlc_pkg::ST_IDLE: begin
        if (accept) begin
          removed_d = '0;
          found_d   = 1'b0;
          fval_d    = '0;
        end
      end
      ttlc_pkg::ST_MATCH: begin
        ctl.act = ttlc_pkg::ACT_MATCH;
        found_d = ch_any[CAPACITY];
        rref_d  = ch_rank[CAPACITY];
        if (cmd_q == ttlc_pkg::CMD_LOOKUP) fval_d = ch_val[CAPACITY];
      end
      ttlc_pkg::ST_TOUCH: begin
        ctl.act = ttlc_pkg::ACT_TOUCH;
        ctl.sel = ttlc_pkg::SEL_HIT;
        ctl.wr  = (cmd_q == ttlc_pkg::CMD_INSERT);
      end
      ttlc_pkg::ST_EVICT: begin
        ctl.sel = ttlc_pkg::SEL_LRU;
        rref    = RW'(count_q - 1'b1);
        if (9'(count_q) >= lim) begin
          ctl.act   = ttlc_pkg::ACT_REMOVE;
          count_d   = count_q - 1'b1;
          removed_d = (removed_q == 5'd31) ? removed_q : removed_q + 5'd1;
        end
      end
      ttlc_pkg::ST_ALLOC: begin
        ctl.act = ttlc_pkg::ACT_ALLOC;
        ctl.sel = ttlc_pkg::SEL_FREE;
        count_d = count_q + 1'b1;
      end
      ttlc_pkg::ST_SWEEP: begin
        ctl.sel = ttlc_pkg::SEL_EXP;
        rref    = ch_rank[CAPACITY];
        if (ch_any[CAPACITY]) begin
          ctl.act   = ttlc_pkg::ACT_REMOVE;
          count_d   = count_q - 1'b1;
          removed_d = (removed_q == 5'd31) ? removed_q : removed_q + 5'd1;
        end
      end
      ttlc_pkg::ST_DONE: begin
        if (!ov_q || out_ready_i) begin
          ov_d  = 1'b1;
          fo_d  = found_q;
          fvo_d = fval_q;
          rco_d = removed_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ttlc_pkg::ST_IDLE;
      max_q   <= ttlc_pkg::MAX_ENTRIES_RST;
      count_q <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ov_q    <= ov_d;
      if (cfg_valid_i && cfg_ready_o) max_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= ttlc_pkg::cmd_e'(command_i);
      key_q <= key_i[KW-1:0];
      val_q <= value_handle_i;
      exp_q <= sum[32] ? 32'hFFFF_FFFF : sum[31:0];
      now_q <= now_time_i;
    end
    removed_q <= removed_d;
    found_q   <= found_d;
    fval_q    <= fval_d;
    rref_q    <= rref_d;
    fo_q      <= fo_d;
    fvo_q     <= fvo_d;
    rco_q     <= rco_d;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_vec) == 32'(count_q))
    else $error("entry count differs from valid cells");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= CAPACITY)
    else $error("entry count above capacity");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ttlc_pkg::ST_ALLOC |-> !ch_first[CAPACITY])
    else $error("allocation without a free cell");

endmodule

/* sim/testbench.sv */
module testbench;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [4:0]  cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  command_i = ttlc_pkg::CMD_LOOKUP;
  logic [31:0] key_i = '0;
  logic [31:0] value_handle_i = '0;
  logic [23:0] freshness_i = '0;
  logic [31:0] now_time_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        found_o;
  logic [31:0] found_value_o;
  logic [4:0]  removed_count_o;

  ttl_lru_cache_core dut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_data_i,
    .in_valid_i, .in_ready_o, .command_i, .key_i, .value_handle_i,
    .freshness_i, .now_time_i, .out_valid_o, .out_ready_i,
    .found_o, .found_value_o, .removed_count_o
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  typedef struct packed {
    logic        found;
    logic [31:0] found_value;
    logic [4:0]  removed_count;
  } cache_reply_t;

  localparam int NSLOT = 16;

  logic [4:0]   limit_q;
  logic         slot_valid [NSLOT];
  logic [31:0]  slot_key [NSLOT];
  logic [31:0]  slot_value [NSLOT];
  logic [31:0]  slot_expiry [NSLOT];
  int unsigned  slot_rank [NSLOT];
  int unsigned  live_q;
  cache_reply_t pending_replies[$];
  int           errors = 0;
  logic [31:0]  clock_now = 32'd1000;
  logic [31:0]  recent_keys [8];

  function automatic int find_slot(logic [31:0] k);
    for (int i = 0; i < NSLOT; i++)
      if (slot_valid[i] && slot_key[i] == k) return i;
    return -1;
  endfunction

  function automatic void promote(int s);
    int unsigned r;
    r = slot_rank[s];
    for (int i = 0; i < NSLOT; i++)
      if (slot_valid[i] && slot_rank[i] < r) slot_rank[i]++;
    slot_rank[s] = 0;
  endfunction

  function automatic void drop_slot(int s);
    int unsigned r;
    r = slot_rank[s];
    slot_valid[s] = 1'b0;
    live_q--;
    for (int i = 0; i < NSLOT; i++)
      if (slot_valid[i] && slot_rank[i] > r) slot_rank[i]--;
  endfunction

  function automatic cache_reply_t predict_cache(ttlc_pkg::cmd_e cmd, logic [31:0] k,
      logic [31:0] v, logic [23:0] fr, logic [31:0] now);
    cache_reply_t rep;
    int s;
    int unsigned lim, removed;
    logic [32:0] sum;
    logic [31:0] exp32;
    rep = '0;
    removed = 0;
    case (cmd)
      ttlc_pkg::CMD_LOOKUP: begin
        s = find_slot(k);
        if (s >= 0) begin
          rep.found = 1'b1;
          rep.found_value = slot_value[s];
          promote(s);
        end
      end
      ttlc_pkg::CMD_INSERT: begin
        sum = {1'b0, now} + {9'b0, fr};
        exp32 = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        s = find_slot(k);
        if (s >= 0) begin
          rep.found = 1'b1;
          promote(s);
        end else begin
          lim = limit_q;
          if (lim == 0) lim = 1;
          if (lim > NSLOT) lim = NSLOT;
          while (live_q >= lim) begin
            for (int i = 0; i < NSLOT; i++)
              if (slot_valid[i] && slot_rank[i] + 1 == live_q) begin
                drop_slot(i);
                break;
              end
            removed++;
          end
          s = 0;
          while (s < NSLOT && slot_valid[s]) s++;
          for (int i = 0; i < NSLOT; i++)
            if (slot_valid[i]) slot_rank[i]++;
          slot_valid[s] = 1'b1;
          slot_key[s] = k;
          slot_rank[s] = 0;
          live_q++;
        end
        slot_value[s] = v;
        slot_expiry[s] = exp32;
      end
      ttlc_pkg::CMD_SWEEP: begin
        for (int i = 0; i < NSLOT; i++)
          if (slot_valid[i] && slot_expiry[i] < now) begin
            drop_slot(i);
            removed++;
          end
      end
      default: ;
    endcase
    rep.removed_count = removed > 31 ? 5'd31 : removed[4:0];
    return rep;
  endfunction

  task automatic send_request(ttlc_pkg::cmd_e cmd, logic [31:0] k, logic [31:0] v,
      logic [23:0] fr, logic [31:0] now);
    int gap;
    gap = $urandom_range(0, 13);
    if ($urandom_range(0, 3) == 0) gap = 0;
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i <= cmd;
    key_i <= k;
    value_handle_i <= v;
    freshness_i <= fr;
    now_time_i <= now;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_replies.push_back(predict_cache(cmd, k, v, fr, now));
  endtask

  always @(posedge clk_i) begin
    cache_reply_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_replies.size() == 0) begin
        $error("unexpected result");
        errors++;
      end else begin
        want = pending_replies[0];
        pending_replies.delete(0);
        if (found_o !== want.found) begin
          $error("found exp %0h got %0h", want.found, found_o);
          errors++;
        end
        if (found_value_o !== want.found_value) begin
          $error("found_value exp %0h got %0h", want.found_value, found_value_o);
          errors++;
        end
        if (removed_count_o !== want.removed_count) begin
          $error("removed_count exp %0h got %0h", want.removed_count,
                 removed_count_o);
          errors++;
        end
      end
    end
  end

  initial begin
    int stall;
    forever begin
      @(negedge clk_i);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        stall--;
      end else begin
        out_ready_i <= 1'b1;
        if (out_valid_o) stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 13);
      end
    end
  end

  task automatic drain;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_replies.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  task automatic write_limit(logic [4:0] lim);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= lim;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    limit_q = lim;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_directed;
    write_limit(5'd2);
    send_request(ttlc_pkg::CMD_LOOKUP, 32'h0, 32'h0, 24'h0, 32'h0);
    send_request(ttlc_pkg::CMD_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'hFF_FFFF,
                 32'hFFFF_FFF0);
    send_request(ttlc_pkg::CMD_INSERT, 32'h0, 32'h1234, 24'h0, 32'h0);
    send_request(ttlc_pkg::CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0, 24'h0, 32'h0);
    send_request(ttlc_pkg::CMD_INSERT, 32'h5, 32'h55, 24'h10, 32'h10);
    send_request(ttlc_pkg::CMD_LOOKUP, 32'h0, 32'h0, 24'h0, 32'h0);
    send_request(ttlc_pkg::CMD_INSERT, 32'h5, 32'h66, 24'h1, 32'h20);
    send_request(ttlc_pkg::CMD_NONE, 32'h5, 32'h1, 24'h1, 32'hFFFF_FFFF);
    send_request(ttlc_pkg::CMD_SWEEP, 32'h0, 32'h0, 24'h0, 32'h21);
    send_request(ttlc_pkg::CMD_SWEEP, 32'h0, 32'h0, 24'h0, 32'h22);
    send_request(ttlc_pkg::CMD_SWEEP, 32'h0, 32'h0, 24'h0, 32'hFFFF_FFFF);
    write_limit(5'd0);
    send_request(ttlc_pkg::CMD_INSERT, 32'h7, 32'h7, 24'h3, 32'h0);
    send_request(ttlc_pkg::CMD_INSERT, 32'h8, 32'h8, 24'h3, 32'h0);
    write_limit(5'd31);
    for (int i = 0; i < 17; i++)
      send_request(ttlc_pkg::CMD_INSERT, 32'h100 + i, i, 24'h5, 32'h0);
    write_limit(5'd3);
    send_request(ttlc_pkg::CMD_INSERT, 32'h999, 32'h9, 24'h0, 32'h0);
  endtask

  task automatic test_random(int n);
    ttlc_pkg::cmd_e cmd;
    logic [31:0] k;
    int pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      cmd = pick < 40 ? ttlc_pkg::CMD_INSERT : pick < 80 ? ttlc_pkg::CMD_LOOKUP :
            pick < 95 ? ttlc_pkg::CMD_SWEEP : ttlc_pkg::CMD_NONE;
      k = $urandom_range(0, 3) == 0 ? $urandom() : recent_keys[$urandom_range(0, 7)];
      clock_now = clock_now + $urandom_range(0, 40);
      if ($urandom_range(0, 60) == 0) clock_now = $urandom();
      send_request(cmd, k, $urandom(),
                   24'($urandom_range(0, 7) == 0 ? $urandom() : $urandom_range(0, 300)),
                   $urandom_range(0, 9) == 0 ? $urandom() : clock_now);
    end
  endtask

  initial begin
    for (int i = 0; i < NSLOT; i++) begin
      slot_valid[i] = 1'b0;
      slot_key[i] = '0;
      slot_value[i] = '0;
      slot_expiry[i] = '0;
      slot_rank[i] = 0;
    end
    for (int i = 0; i < 8; i++) recent_keys[i] = $urandom();
    live_q = 0;
    limit_q = ttlc_pkg::MAX_ENTRIES_RST;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_random(30);
    test_directed();
    write_limit(5'd16);
    test_random(400);
    drain();
    write_limit(5'd4);
    test_random(400);
    write_limit(5'd1);
    test_random(300);
    write_limit(5'd9);
    test_random(300);
    write_limit(5'd20);
    test_random(250);
    drain();
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    #8000000;
    $display("FAIL");
    $finish;
  end
endmodule
